[sv/mms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_pkg: shared types and constants
// Kinds, tune depth, beat length, divider types and the note frequency table.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int TuneDepth = 256;
  localparam int AddrW     = $clog2(TuneDepth);
  localparam int PosW      = AddrW + 1;

  localparam logic [1:0] KIND_TONE = 2'd0;
  localparam logic [1:0] KIND_REST = 2'd1;
  localparam logic [1:0] KIND_SYNC = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [32:0] BEAT_US = 33'd15000000;

  // divider request / response
  typedef struct packed {
    logic        start;
    logic [35:0] num;
    logic [35:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [35:0] quo;
  } div_rsp_t;

  function automatic logic [13:0] note_freq(input logic [7:0] c);
    case (c)
      8'h63:   note_freq = 14'd4186;
      8'h64:   note_freq = 14'd4699;
      8'h65:   note_freq = 14'd5274;
      8'h66:   note_freq = 14'd5588;
      8'h67:   note_freq = 14'd6272;
      8'h61:   note_freq = 14'd7040;
      8'h62:   note_freq = 14'd7902;
      default: note_freq = 14'd0;
    endcase
  endfunction

endpackage

[sv/mms_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_div: radix-2 restoring divider
// One quotient bit per cycle while busy; a new start restarts the division.
// ----------------------------------------------------------------------------
module mms_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mms_pkg::div_req_t req,
  output mms_pkg::div_rsp_t rsp
);
  import mms_pkg::*;

  logic [35:0] quo_r, quo_nxt;
  logic [36:0] rem_r, rem_nxt;
  logic [35:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [36:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[35:0], quo_r[35]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[34:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[34:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd35) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (req.start) den_r <= req.den;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

[sv/music_macro_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_macro_sequencer: tune store and macro-language interpreter
// Loads tune characters, then steps through them to produce one event per
// "next" request.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in_     | input     | in_valid/stall   | action, address, character, last_char
// out_    | output    | out_valid/stall  | kind, tone_freq, play/gap time, error
// cfg_    | input     | cfg_we           | volume
//
// A "next" steps through decode, look-ahead and store read for each
// character scanned, and a digit read and a digit step for each setting
// digit; for a note it then runs 3 multiply steps and up to two passes
// through the shared serial divider. Reset is synchronous; the
// store is not cleared. A new item is taken while the last result waits on
// out_stall.
// ----------------------------------------------------------------------------
module music_macro_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_address,
  input  logic [7:0]  in_character,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [13:0] out_tone_freq,
  output logic [28:0] out_play_time_us,
  output logic [28:0] out_gap_time_us,
  output logic        out_tempo_error,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_volume
);
  import mms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DECODE, S_DIGIT_RD, S_DIGIT, S_LOOK, S_NOTE1, S_NOTE2,
    S_NOTE3, S_DIV1, S_DIV2, S_EMIT
  } state_t;

  typedef enum logic [1:0] { DG_OCT, DG_LEN, DG_TEMPO, DG_REP } dig_t;

  logic [7:0] store [TuneDepth];
  logic [7:0] rd_data_r;
  logic [AddrW-1:0] rd_addr;

  state_t      state_r;
  dig_t        dig_r;
  logic [3:0]  volume_r;
  logic [PosW-1:0] len_r, pos_r, np_r, rep_start_r;
  logic [PosW-1:0] pos_inc;
  logic [13:0] pfreq_r;
  logic        supp_r, rep_valid_r;
  logic signed [7:0] oct_now_r, oct_base_r;
  logic [19:0] nlen_r;
  logic [15:0] dlen_r, tempo_r;
  logic [1:0]  acc_r;
  logic [7:0]  ratio_r, rep_left_r;
  logic [2:0]  dots_r;
  logic [16:0] dval_r;
  logic [13:0] f_r;
  logic [4:0]  r_r;
  logic [32:0] tb_r;
  logic [35:0] db_r;
  logic [28:0] pt_r;
  logic        pend_r;
  logic [7:0]  pend_addr_r, pend_char_r;
  logic        pend_act_r, pend_last_r;

  logic        o_valid_r;
  logic [1:0]  o_kind_r;
  logic [13:0] o_freq_r;
  logic [28:0] o_pt_r, o_gt_r;
  logic        o_err_r;

  div_req_t dreq;
  div_rsp_t drsp;

  mms_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [7:0]  cl;
  logic        is_dig, is_alpha;
  logic [20:0] dsum;
  logic [3:0]  oct_c;
  logic [13:0] f_sh;
  logic [25:0] f_mul;
  logic [36:0] tb_mul;
  logic [16:0] dcap;

  assign cl       = (rd_data_r >= 8'h41 && rd_data_r <= 8'h5a) ? rd_data_r + 8'd32
                                                                : rd_data_r;
  assign is_dig   = rd_data_r >= 8'h30 && rd_data_r <= 8'h39;
  assign is_alpha = (cl >= 8'h61 && cl <= 8'h7a);
  assign dsum     = {4'd0, dval_r} * 21'd10 + {17'd0, rd_data_r[3:0]};
  assign pos_inc  = pos_r + 1'b1;

  always_comb begin
    case (dig_r)
      DG_OCT:  dcap = 17'd127;
      DG_REP:  dcap = 17'd255;
      default: dcap = 17'd65535;
    endcase
  end

  assign oct_c  = oct_now_r < 0 ? 4'd0 : (oct_now_r > 8 ? 4'd8 : oct_now_r[3:0]);
  assign f_sh   = pfreq_r >> (4'd8 - oct_c);
  assign f_mul  = (f_r * 26'd3900) >> 16;
  // beat * (2^(d+1) - 1) / 2^d
  assign tb_mul = (({4'd0, BEAT_US} << (dots_r + 3'd1)) - {4'd0, BEAT_US}) >> dots_r;

  assign in_stall  = (state_r != S_IDLE) || pend_r;
  assign out_valid = o_valid_r;
  assign out_kind         = o_kind_r;
  assign out_tone_freq    = o_freq_r;
  assign out_play_time_us = o_pt_r;
  assign out_gap_time_us  = o_gt_r;
  assign out_tempo_error  = o_err_r;

  // decode fetches the look-ahead character, or the loop head on a taken ]
  always_comb begin
    rd_addr = pos_r[AddrW-1:0];
    if (state_r == S_DECODE) begin
      if (cl == 8'h5d && rep_valid_r && rep_left_r > 8'd1)
        rd_addr = rep_start_r[AddrW-1:0];
      else
        rd_addr = pos_inc[AddrW-1:0];
    end else if (state_r == S_DIGIT_RD) begin
      rd_addr = np_r[AddrW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && pend_r && !pend_act_r)
      store[pend_addr_r[AddrW-1:0]] <= pend_char_r;
    rd_data_r <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE; volume_r <= 4'd4; len_r <= '0; pos_r <= '0;
      pfreq_r <= '0; supp_r <= 1'b0; oct_now_r <= 8'sd4; oct_base_r <= 8'sd4;
      nlen_r <= 20'd4; dlen_r <= 16'd4; tempo_r <= 16'd120; acc_r <= '0;
      ratio_r <= 8'd8; dots_r <= '0; rep_left_r <= '0; rep_start_r <= '0;
      rep_valid_r <= 1'b0; pend_r <= 1'b0; o_valid_r <= 1'b0;
    end else begin
      if (cfg_we) volume_r <= cfg_volume;
      if (o_valid_r && !out_stall) o_valid_r <= 1'b0;
      if (in_valid && !in_stall) begin
        pend_r <= 1'b1; pend_act_r <= in_action; pend_addr_r <= in_address;
        pend_char_r <= in_character; pend_last_r <= in_last_char;
      end
      unique case (state_r)
        S_IDLE: if (pend_r && (!pend_act_r || !o_valid_r)) begin
          pend_r <= 1'b0;
          if (!pend_act_r) begin
            if (pend_last_r) begin
              len_r <= {1'b0, pend_addr_r[AddrW-1:0]} + 1'b1;
              pos_r <= '0; oct_base_r <= 8'sd4; dlen_r <= 16'd4; tempo_r <= 16'd120;
              rep_left_r <= '0; rep_start_r <= '0; rep_valid_r <= 1'b0;
              nlen_r <= 20'd4; oct_now_r <= 8'sd4; acc_r <= '0; pfreq_r <= '0;
              supp_r <= 1'b0; ratio_r <= 8'd8; dots_r <= '0;
            end
          end else if (pos_r >= len_r) begin
            o_valid_r <= 1'b1; o_kind_r <= KIND_END; o_freq_r <= '0;
            o_pt_r <= '0; o_gt_r <= '0; o_err_r <= 1'b0;
          end else begin
            state_r <= S_DECODE;
          end
        end
        S_READ: begin
          if (pos_r >= len_r) begin
            o_kind_r <= KIND_END; o_freq_r <= '0; o_pt_r <= '0; o_gt_r <= '0;
            o_err_r <= 1'b0; state_r <= S_EMIT;
          end else state_r <= S_DECODE;
        end
        S_DECODE: begin
          np_r <= pos_inc;
          dval_r <= '0;
          state_r <= S_LOOK;
          case (cl)
            8'h2b: if (oct_now_r != 8'sd127) oct_now_r <= oct_now_r + 8'sd1;
            8'h2d: if (oct_now_r != -8'sd128) oct_now_r <= oct_now_r - 8'sd1;
            8'h3e: ratio_r <= ratio_r > 8'd251 ? 8'd255 : ratio_r + 8'd4;
            8'h3c: ratio_r <= ratio_r >> 1;
            8'h23: acc_r <= 2'd1;
            8'h5f: acc_r <= 2'd2;
            8'h7e: nlen_r <= ({2'd0, nlen_r} * 22'd3 > 22'hFFFFF) ? 20'hFFFFF
                             : 20'(nlen_r * 20'd3);
            8'h2e: if (dots_r < 3'd6) dots_r <= dots_r + 3'd1;
            8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38:
              nlen_r <= 20'd1 << cl[3:0];
            8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h72, 8'h7a: begin
              pfreq_r <= note_freq(cl); supp_r <= 1'b0;
            end
            8'h73: begin
              pfreq_r <= '0; supp_r <= 1'b1; pos_r <= pos_inc;
              o_kind_r <= KIND_SYNC; o_freq_r <= '0; o_pt_r <= '0; o_gt_r <= '0;
              o_err_r <= 1'b0; state_r <= S_EMIT;
            end
            8'h6f: begin supp_r <= 1'b1; dig_r <= DG_OCT; state_r <= S_DIGIT_RD; end
            8'h6c: begin supp_r <= 1'b1; dig_r <= DG_LEN; state_r <= S_DIGIT_RD; end
            8'h74, 8'h40: begin
              supp_r <= 1'b1; dig_r <= DG_TEMPO; state_r <= S_DIGIT_RD;
            end
            8'h5b: begin dig_r <= DG_REP; state_r <= S_DIGIT_RD; end
            8'h5d: if (rep_valid_r && rep_left_r > 8'd1) begin
              rep_left_r <= rep_left_r - 8'd1; np_r <= rep_start_r;
            end else rep_left_r <= '0;
            default: ;
          endcase
        end
        S_DIGIT_RD: state_r <= S_DIGIT;
        S_DIGIT: begin
          if (np_r < len_r && is_dig) begin
            dval_r <= dsum > {4'd0, dcap} ? dcap : dsum[16:0];
            np_r <= np_r + 1'b1;
            state_r <= S_DIGIT_RD;
          end else begin
            case (dig_r)
              DG_OCT: begin
                oct_base_r <= 8'(dval_r); oct_now_r <= 8'(dval_r);
              end
              DG_LEN: begin dlen_r <= dval_r[15:0]; nlen_r <= {4'd0, dval_r[15:0]}; end
              DG_TEMPO: tempo_r <= dval_r[15:0];
              default: begin
                rep_left_r <= dval_r[7:0]; rep_start_r <= np_r; rep_valid_r <= 1'b1;
              end
            endcase
            pos_r <= np_r;
            if (!supp_r && (np_r >= len_r || is_alpha)) state_r <= S_NOTE1;
            else state_r <= S_READ;
          end
        end
        S_LOOK: begin
          pos_r <= np_r;
          if (!supp_r && (np_r >= len_r || is_alpha)) state_r <= S_NOTE1;
          else state_r <= S_READ;
        end
        S_NOTE1: begin
          f_r <= f_sh;
          r_r <= ratio_r == 8'd0 ? 5'd1 : (ratio_r > 8'd16 ? 5'd16 : ratio_r[4:0]);
          tb_r <= dots_r != 3'd0 ? tb_mul[32:0] : BEAT_US;
          db_r <= nlen_r * tempo_r;
          state_r <= S_NOTE2;
        end
        S_NOTE2: begin
          if (acc_r == 2'd1) f_r <= f_r + f_mul[13:0];
          else if (acc_r == 2'd2) f_r <= f_r - f_mul[13:0];
          state_r <= S_NOTE3;
        end
        S_NOTE3: begin
          o_kind_r <= (f_r != 0 && volume_r != 0) ? KIND_TONE : KIND_REST;
          o_freq_r <= (f_r != 0 && volume_r != 0) ? f_r : 14'd0;
          o_err_r  <= db_r == 0;
          nlen_r <= {4'd0, dlen_r}; oct_now_r <= oct_base_r; acc_r <= '0;
          pfreq_r <= '0; supp_r <= 1'b0; ratio_r <= 8'd8; dots_r <= '0;
          if (db_r == 0) begin
            o_pt_r <= '0; o_gt_r <= '0; state_r <= S_EMIT;
          end else begin
            dreq.num <= 36'(tb_r * r_r); dreq.den <= db_r; dreq.start <= 1'b1;
            state_r <= S_DIV1;
          end
        end
        S_DIV1: if (drsp.done) begin
          pt_r <= drsp.quo[28:0];
          if (r_r == 5'd16) begin
            o_pt_r <= drsp.quo[28:0]; o_gt_r <= '0; state_r <= S_EMIT;
          end else begin
            dreq.num <= 36'(tb_r * (5'd16 - r_r)); dreq.start <= 1'b1;
            state_r <= S_DIV2;
          end
        end
        S_DIV2: if (drsp.done) begin
          o_pt_r <= pt_r; o_gt_r <= drsp.quo[28:0]; state_r <= S_EMIT;
        end
        S_EMIT: begin o_valid_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/sv/tb_music_macro_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_music_macro_sequencer: self-checking bench for the tune interpreter
// Loads tunes built from random well-formed macro tokens (plus noise),
// pulls events with "next" transfers and checks every event against an
// in-bench interpreter. Both channels idle at random; the receiver also
// holds off for a long stretch to fill the block up.
// ----------------------------------------------------------------------------
module tb_music_macro_sequencer;
  import mms_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [13:0] freq;
    logic [28:0] play_us;
    logic [28:0] gap_us;
    logic        err;
  } mml_event_t;

  class tune_event_board;
    byte unsigned store[256];
    int unsigned  tlen, rpos, pfreq, nlen, dlen, tempo, acc, ratio, dots;
    int unsigned  rleft, rstart, vol;
    int           oct_now, oct_base;
    bit           supp, rvalid;
    mml_event_t   due[$];
    int           errors;
    int           n_kind[4];

    function new();
      foreach (store[i]) store[i] = 0;
      tlen = 0;
      vol = 4;
      rewind();
    endfunction

    function void clear_note();
      nlen = dlen;
      oct_now = oct_base;
      acc = 0;
      pfreq = 0;
      supp = 0;
      ratio = 8;
      dots = 0;
    endfunction

    function void rewind();
      rpos = 0;
      oct_base = 4;
      dlen = 4;
      tempo = 120;
      rleft = 0;
      rstart = 0;
      rvalid = 0;
      clear_note();
    endfunction

    function bit is_digit(byte unsigned c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(byte unsigned c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function int unsigned read_digits(inout int unsigned np, input int unsigned cap);
      int unsigned v;
      v = 0;
      while (np < tlen && is_digit(store[np])) begin
        v = v * 10 + (store[np] - "0");
        if (v > cap) v = cap;
        np++;
      end
      return v;
    endfunction

    function void push(logic [1:0] k, int unsigned f, longint pt, longint gt, bit e);
      mml_event_t ev;
      ev.kind = k;
      ev.freq = f[13:0];
      ev.play_us = pt[28:0];
      ev.gap_us = gt[28:0];
      ev.err = e;
      due.push_back(ev);
    endfunction

    function void play();
      int          o;
      int unsigned f, r;
      longint      beat, db, pt, gt;
      bit          e;
      o = oct_now;
      if (o < 0) o = 0;
      if (o > 8) o = 8;
      f = pfreq >> (8 - o);
      if (acc == 1) f += (f * 3900) / 65536;
      else if (acc == 2) f -= (f * 3900) / 65536;
      r = ratio;
      if (r < 1) r = 1;
      if (r > 16) r = 16;
      beat = 15000000;
      if (dots != 0) beat = (beat * ((2 << dots) - 1)) >> dots;
      db = longint'(nlen) * tempo;
      pt = 0;
      gt = 0;
      e = 0;
      if (db == 0) e = 1;
      else begin
        pt = beat * r / db;
        if (r != 16) gt = beat * (16 - r) / db;
      end
      if (f != 0 && vol != 0) push(KIND_TONE, f, pt, gt, e);
      else push(KIND_REST, 0, pt, gt, e);
      clear_note();
    endfunction

    // one accepted input transfer
    function void note_input(bit act, byte unsigned adr, byte unsigned ch, bit last);
      int unsigned np, v;
      byte unsigned c;
      if (!act) begin
        store[adr] = ch;
        if (last) begin
          tlen = adr + 1;
          rewind();
        end
        return;
      end
      forever begin
        if (rpos >= tlen) begin
          push(KIND_END, 0, 0, 0, 0);
          return;
        end
        c = store[rpos];
        if (c >= "A" && c <= "Z") c = c + 32;
        np = rpos + 1;
        case (c)
          "+": if (oct_now < 127) oct_now++;
          "-": if (oct_now > -128) oct_now--;
          ">": ratio = ratio > 251 ? 255 : ratio + 4;
          "<": ratio = ratio / 2;
          "#": acc = 1;
          "_": acc = 2;
          "~": nlen = nlen * 3 > 'hFFFFF ? 'hFFFFF : nlen * 3;
          ".": if (dots < 6) dots++;
          "0", "1", "2", "3", "4", "5", "6", "7", "8": nlen = 1 << (c - "0");
          "c": begin pfreq = 4186; supp = 0; end
          "d": begin pfreq = 4699; supp = 0; end
          "e": begin pfreq = 5274; supp = 0; end
          "f": begin pfreq = 5588; supp = 0; end
          "g": begin pfreq = 6272; supp = 0; end
          "a": begin pfreq = 7040; supp = 0; end
          "b": begin pfreq = 7902; supp = 0; end
          "r", "z": begin pfreq = 0; supp = 0; end
          "s": begin
            pfreq = 0;
            supp = 1;
            rpos = np;
            push(KIND_SYNC, 0, 0, 0, 0);
            return;
          end
          "o": begin
            supp = 1;
            v = read_digits(np, 127);
            oct_base = v;
            oct_now = v;
          end
          "l": begin
            supp = 1;
            dlen = read_digits(np, 65535);
            nlen = dlen;
          end
          "t", "@": begin
            supp = 1;
            tempo = read_digits(np, 65535);
          end
          "[": begin
            rleft = read_digits(np, 255);
            rstart = np;
            rvalid = 1;
          end
          "]": begin
            if (rvalid && rleft > 1) begin
              rleft--;
              np = rstart;
            end else rleft = 0;
          end
          default: ;
        endcase
        rpos = np;
        if (!supp && (np >= tlen || is_alpha(store[np]))) begin
          play();
          return;
        end
      end
    endfunction

    function void report(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(mml_event_t got);
      mml_event_t ev;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, kind %0d freq %0d", $time, got.kind, got.freq);
        return;
      end
      ev = due.pop_front();
      n_kind[ev.kind]++;
      report("kind", ev.kind, got.kind);
      report("tone_freq", ev.freq, got.freq);
      report("play_time_us", ev.play_us, got.play_us);
      report("gap_time_us", ev.gap_us, got.gap_us);
      report("tempo_error", ev.err, got.err);
    endfunction
  endclass

  localparam int StallLimit = 400000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_action, in_last_char;
  logic [7:0]  in_address, in_character;
  logic        out_valid, out_stall, out_tempo_error;
  logic [1:0]  out_kind;
  logic [13:0] out_tone_freq;
  logic [28:0] out_play_time_us, out_gap_time_us;
  logic        cfg_we;
  logic [3:0]  cfg_volume;

  tune_event_board board;
  bit          calm, hold_req;
  bit          written[256];
  byte unsigned tune[$];
  int          items_sent, idle_cycles, vol_writes;

  music_macro_sequencer u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_address, .in_character,
    .in_last_char, .out_valid, .out_stall, .out_kind, .out_tone_freq,
    .out_play_time_us, .out_gap_time_us, .out_tempo_error, .cfg_we, .cfg_volume
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    mml_event_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.kind = out_kind;
        got.freq = out_tone_freq;
        got.play_us = out_play_time_us;
        got.gap_us = out_gap_time_us;
        got.err = out_tempo_error;
        board.check_result(got);
      end
      if (in_valid && !in_stall)
        board.note_input(in_action, in_address, in_character, in_last_char);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("[music_macro_sequencer] ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side: random stall, one long hold-off on request
  initial begin
    int k;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (1500) @(negedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else begin
        k = pick_gap();
        out_stall <= (k != 0);
        if (k > 1) repeat (k - 1) @(negedge clk);
      end
    end
  end

  task automatic send_item(bit act, byte unsigned adr, byte unsigned ch, bit last);
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_address <= adr;
    in_character <= ch;
    in_last_char <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (!act) written[adr] = 1;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.due.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_volume(logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_volume <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.vol = v;
    vol_writes++;
  endtask

  task automatic load_tune();
    foreach (tune[i]) send_item(1'b0, i, tune[i], i == tune.size() - 1);
  endtask

  task automatic add_text(string s);
    foreach (s[i]) tune.push_back(s[i]);
  endtask

  task automatic add_number(bit octave);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) add_text("0");
    else if (r < 55 || octave && r < 85) add_text($sformatf("%0d", $urandom_range(1, 9)));
    else if (r < 90) add_text($sformatf("%0d", $urandom_range(10, 300)));
    else add_text("99999");
  endtask

  task automatic add_token(bit allow_repeat);
    string notes = "abcdefgABCDEFGrRzZ";
    string mods = "#_+-.~<>012345678";
    string noise = " !x9Q\n";
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      tune.push_back(notes[$urandom_range(0, notes.len() - 1)]);
      n = $urandom_range(0, 3);
      repeat (n) tune.push_back(mods[$urandom_range(0, mods.len() - 1)]);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(6, 9)) tune.push_back(".");
      if ($urandom_range(0, 12) == 0) repeat ($urandom_range(3, 8)) tune.push_back(">");
    end else if (r < 62) begin
      tune.push_back($urandom_range(0, 1) ? "O" : "o");
      add_number(1);
    end else if (r < 68) begin
      tune.push_back($urandom_range(0, 1) ? "L" : "l");
      add_number(0);
    end else if (r < 74) begin
      tune.push_back($urandom_range(0, 2) == 0 ? "@" : "T");
      add_number(0);
    end else if (r < 80) tune.push_back($urandom_range(0, 1) ? "S" : "s");
    else if (r < 88 && allow_repeat) begin
      tune.push_back("[");
      if ($urandom_range(0, 15) == 0) add_text("300");
      else add_text($sformatf("%0d", $urandom_range(0, 4)));
      repeat ($urandom_range(1, 3)) add_token(0);
      tune.push_back("]");
    end else if (r < 94) tune.push_back(8'h00);
    else tune.push_back(noise[$urandom_range(0, noise.len() - 1)]);
  endtask

  task automatic build_tune(int target);
    tune.delete();
    while (tune.size() < target) add_token(1);
    while (tune.size() > 256) void'(tune.pop_back());
  endtask

  initial begin
    int phase, n, r;
    bit all_written;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = 1'b0;
    in_address = '0;
    in_character = '0;
    in_last_char = 1'b0;
    cfg_we = 1'b0;
    cfg_volume = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: next on empty store, zero tempo and length, octave floor,
    // flat, one repeat, a play-ratio step and a sync at the tail
    send_item(1'b1, 0, 0, 0);
    tune.delete();
    add_text("T0cL0dO0-e_[2f]>S");
    load_tune();
    repeat (7) send_item(1'b1, 0, 0, 0);
    wait_idle();

    // whole store once, so later noise may end a tune anywhere
    set_volume(4'd15);
    build_tune(256);
    load_tune();
    repeat (20) send_item(1'b1, 0, 0, 0);
    wait_idle();

    phase = 0;
    while (items_sent < 580) begin
      case (phase % 5)
        0: set_volume(4'd0);
        1: set_volume(4'd4);
        2: set_volume(4'd15);
        3: set_volume(4'd1);
        default: set_volume($urandom_range(0, 15));
      endcase
      calm = (phase % 4 == 3);
      build_tune($urandom_range(8, 50));
      load_tune();
      if (phase == 2) hold_req = 1;
      n = (phase == 2) ? 40 : $urandom_range(5, 25);
      all_written = 1;
      foreach (written[i]) all_written &= written[i];
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 8) send_item(1'b0, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
        else if (r < 11 && all_written)
          send_item(1'b0, $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
        else send_item(1'b1, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 1));
      end
      wait_idle();
      phase++;
    end
    calm = 0;
    wait_idle();

    $display("Sent %0d input transfers over %0d volume settings", items_sent, vol_writes);
    $display("Events: %0d tone, %0d silence, %0d sync, %0d end",
             board.n_kind[KIND_TONE], board.n_kind[KIND_REST],
             board.n_kind[KIND_SYNC], board.n_kind[KIND_END]);
    if (board.errors == 0 && board.due.size() == 0) $display("[music_macro_sequencer] OK");
    else $display("[music_macro_sequencer] ERROR");
    $finish;
  end

endmodule
